@@ sv/ssos_pkg.sv @@
// ssos_pkg: shared constants, codes and types for the sensor statistics unit
// used by ssos_fin_unit and sensor_sigma_outlier_stats_unit
package ssos_pkg;

  localparam int NUM_SENSORS = 32;
  localparam int SAMPLE_BITS = 24;
  localparam int SLOT_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

  localparam logic [1:0] CMD_ACC   = 2'd0;
  localparam logic [1:0] CMD_FIN   = 2'd1;
  localparam logic [1:0] CMD_CHECK = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam logic [2:0] KIND_TEMP   = 3'd0;
  localparam logic [2:0] KIND_ENERGY = 3'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_ALERT   = 2'd1;
  localparam logic [1:0] STATUS_CRIT    = 2'd2;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd3;

  localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;
  localparam logic [22:0] DEV_MAX   = 23'h7FFFFF;
  localparam logic [3:0]  SIGMA_RESET = 4'd3;

  localparam longint SMP_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam longint SMP_LO = -SMP_HI - 64'sd1;

  typedef struct packed {
    logic signed [47:0] sum;
    logic [63:0]        sq;
    logic [23:0]        cnt;
  } acc_entry_t;

  typedef struct packed {
    logic signed [23:0] mean;
    logic [22:0]        dev;
  } stat_entry_t;

  typedef struct packed {
    logic               done;
    logic signed [23:0] mean;
    logic [22:0]        dev;
  } fin_res_t;

  // clamp the raw reading to the configured sample range
  function automatic logic signed [23:0] sat_sample(input logic signed [23:0] raw);
    logic signed [63:0] v;
    logic signed [23:0] r;
    v = 64'(raw);
    if (v > SMP_HI) begin
      r = 24'(SMP_HI);
    end else if (v < SMP_LO) begin
      r = 24'(SMP_LO);
    end else begin
      r = raw;
    end
    return r;
  endfunction

endpackage

@@ sv/ssos_fin_unit.sv @@
// ssos_fin_unit: iterative mean and deviation of one sensor entry
// restoring divider (one bit a cycle, used twice) then bit-pair square root
// uses ssos_pkg
module ssos_fin_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  ssos_pkg::acc_entry_t entry,
  output ssos_pkg::fin_res_t   res
);

  typedef enum logic [2:0] {F_IDLE, F_DIV, F_MUL, F_VAR, F_SQRT, F_DONE} fstate_t;

  fstate_t            state_r, state_nxt;
  logic [63:0]        dvd_r, dvd_nxt;
  logic [23:0]        rem_r, rem_nxt;
  logic [23:0]        cnt_r, cnt_nxt;
  logic [63:0]        sq_r, sq_nxt;
  logic               neg_r, neg_nxt;
  logic               pass_r, pass_nxt;
  logic [5:0]         step_r, step_nxt;
  logic signed [23:0] mean_r, mean_nxt;
  logic [63:0]        msq_r, msq_nxt;
  logic [47:0]        m2_r, m2_nxt;
  logic [63:0]        x_r, x_nxt;
  logic [63:0]        root_r, root_nxt;
  logic [63:0]        bit_r, bit_nxt;

  logic [24:0]        trial;
  logic               qbit;
  logic [63:0]        rb;
  logic [47:0]        mag;

  always_comb begin
    state_nxt = state_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    sq_nxt    = sq_r;
    neg_nxt   = neg_r;
    pass_nxt  = pass_r;
    step_nxt  = step_r;
    mean_nxt  = mean_r;
    msq_nxt   = msq_r;
    m2_nxt    = m2_r;
    x_nxt     = x_r;
    root_nxt  = root_r;
    bit_nxt   = bit_r;
    trial     = {rem_r, dvd_r[63]};
    qbit      = (trial >= {1'b0, cnt_r});
    rb        = root_r + bit_r;
    mag       = entry.sum[47] ? 48'(-entry.sum) : 48'(entry.sum);
    case (state_r)
      F_IDLE: begin
        if (start) begin
          neg_nxt   = entry.sum[47];
          dvd_nxt   = {16'd0, mag};
          rem_nxt   = '0;
          cnt_nxt   = entry.cnt;
          sq_nxt    = entry.sq;
          pass_nxt  = 1'b0;
          step_nxt  = '0;
          state_nxt = F_DIV;
        end
      end
      F_DIV: begin
        rem_nxt  = qbit ? 24'(trial - {1'b0, cnt_r}) : trial[23:0];
        dvd_nxt  = {dvd_r[62:0], qbit};
        step_nxt = step_r + 6'd1;
        if (step_r == 6'd63) begin
          if (!pass_r) begin
            // first pass gave the mean magnitude, now divide the square sum
            mean_nxt = neg_r ? -{dvd_r[22:0], qbit} : {dvd_r[22:0], qbit};
            dvd_nxt  = sq_r;
            rem_nxt  = '0;
            pass_nxt = 1'b1;
          end else begin
            msq_nxt   = {dvd_r[62:0], qbit};
            state_nxt = F_MUL;
          end
        end
      end
      F_MUL: begin
        m2_nxt    = 48'(mean_r * mean_r);
        state_nxt = F_VAR;
      end
      F_VAR: begin
        x_nxt     = (msq_r > {16'd0, m2_r}) ? msq_r - {16'd0, m2_r} : '0;
        root_nxt  = '0;
        bit_nxt   = 64'h4000_0000_0000_0000;
        step_nxt  = '0;
        state_nxt = F_SQRT;
      end
      F_SQRT: begin
        if (x_r >= rb) begin
          x_nxt    = x_r - rb;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt  = bit_r >> 2;
        step_nxt = step_r + 6'd1;
        if (step_r == 6'd31) begin
          state_nxt = F_DONE;
        end
      end
      F_DONE: begin
        state_nxt = F_IDLE;
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    sq_r   <= sq_nxt;
    neg_r  <= neg_nxt;
    pass_r <= pass_nxt;
    step_r <= step_nxt;
    mean_r <= mean_nxt;
    msq_r  <= msq_nxt;
    m2_r   <= m2_nxt;
    x_r    <= x_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
  end

  assign res.done = (state_r == F_DONE);
  assign res.mean = mean_r;
  assign res.dev  = (root_r > {41'd0, ssos_pkg::DEV_MAX}) ? ssos_pkg::DEV_MAX : root_r[22:0];

endmodule

@@ sv/sensor_sigma_outlier_stats_unit.sv @@
// sensor_sigma_outlier_stats_unit: top level, per-sensor statistics memories
// uses ssos_pkg and ssos_fin_unit
//
// Accumulate and check requests first read the sensor's entry from the
// synchronous memory, then update it; the result shows on out_* in the cycle
// after the update. A finalize request walks all sensors; a sensor with
// readings goes through the shared divider and square root unit (two 64-step
// divisions, a multiply, a subtract, 32 root steps and a done state) after its
// read, an empty one only through its read. Results appear on out_* for one
// cycle with out_strobe; the receiver cannot stall, so it must take every
// strobe. busy falls in the cycle that carries the last result.
module sensor_sigma_outlier_stats_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic [7:0]         in_sensor_number,
  input  logic [2:0]         in_reading_kind,
  input  logic signed [23:0] in_sample_value,
  input  logic [1:0]         in_reading_status,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_wdata,
  output logic               out_strobe,
  output logic               out_anomaly,
  output logic               out_id_error,
  output logic signed [47:0] out_energy_total,
  output logic [31:0]        out_alert_total,
  output logic [5:0]         out_stat_index,
  output logic signed [23:0] out_stat_mean,
  output logic [22:0]        out_stat_deviation,
  output logic               out_stat_valid,
  output logic               out_last
);

  localparam int N  = ssos_pkg::NUM_SENSORS;
  localparam int SW = ssos_pkg::SLOT_W;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_FRD, S_FWAIT, S_FRUN} state_t;

  ssos_pkg::acc_entry_t  acc_mem [N];
  ssos_pkg::stat_entry_t st_mem [N];
  ssos_pkg::acc_entry_t  acc_rd_r;
  ssos_pkg::stat_entry_t st_rd_r;

  state_t             state_r, state_nxt;
  logic [N-1:0]       acc_vld_r, acc_vld_nxt;
  logic [N-1:0]       st_vld_r, st_vld_nxt;
  logic               acc_vq_r, st_vq_r;
  logic [3:0]         sigma_r;
  logic [1:0]         cmd_r, cmd_nxt;
  logic [2:0]         kind_r, kind_nxt;
  logic signed [23:0] smp_r, smp_nxt;
  logic [1:0]         status_r, status_nxt;
  logic               bad_r, bad_nxt;
  logic [SW-1:0]      slot_r, slot_nxt;
  logic [SW-1:0]      idx_r, idx_nxt;
  logic signed [47:0] energy_r, energy_nxt;
  logic [31:0]        alert_r, alert_nxt;

  logic               o_strobe_nxt, o_anom_nxt, o_iderr_nxt, o_valid_nxt, o_last_nxt;
  logic [5:0]         o_index_nxt;
  logic signed [23:0] o_mean_nxt;
  logic [22:0]        o_dev_nxt;

  logic [7:0]            id_m1;
  logic                  in_bad;
  logic [SW-1:0]         rd_addr;
  logic                  acc_we, st_we;
  logic [SW-1:0]         wr_addr;
  ssos_pkg::acc_entry_t  acc_q, acc_wd;
  ssos_pkg::stat_entry_t st_q, st_wd;
  logic                  fin_start;
  ssos_pkg::fin_res_t    fin_res;
  logic                  temp_ok, acc_act;
  logic [47:0]           sqr;
  logic [64:0]           sq_add;
  logic signed [48:0]    e_add;
  logic [26:0]           dk;
  logic signed [28:0]    m_x, s_x, band_hi, band_lo;
  logic                  anom;
  logic                  idx_end;

  assign id_m1   = in_sensor_number - 8'd1;
  assign in_bad  = (in_sensor_number == 8'd0) || (in_sensor_number > 8'(N));
  assign rd_addr = (state_r == S_IDLE) ? id_m1[SW-1:0] : idx_r;
  assign busy    = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    acc_rd_r <= acc_mem[rd_addr];
    st_rd_r  <= st_mem[rd_addr];
    acc_vq_r <= acc_vld_r[rd_addr];
    st_vq_r  <= st_vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[wr_addr] <= acc_wd;
    end
    if (st_we) begin
      st_mem[wr_addr] <= st_wd;
    end
  end

  // entries never written read as zero
  assign acc_q = acc_vq_r ? acc_rd_r : '0;
  assign st_q  = st_vq_r ? st_rd_r : '0;

  ssos_fin_unit u_fin (
    .clk   (clk),
    .rst_n (rst_n),
    .start (fin_start),
    .entry (acc_q),
    .res   (fin_res)
  );

  assign idx_end = (idx_r == SW'(N - 1));

  always_comb begin
    acc_act  = (cmd_r == ssos_pkg::CMD_ACC) && !bad_r;
    temp_ok  = acc_act && (kind_r == ssos_pkg::KIND_TEMP) && (acc_q.cnt != ssos_pkg::COUNT_MAX);
    sqr      = 48'(smp_r * smp_r);
    sq_add   = {1'b0, acc_q.sq} + {17'd0, sqr};
    e_add    = {energy_r[47], energy_r} + {{25{smp_r[23]}}, smp_r};
    dk       = 27'(st_q.dev * sigma_r);
    m_x      = {{5{st_q.mean[23]}}, st_q.mean};
    s_x      = {{5{smp_r[23]}}, smp_r};
    band_hi  = m_x + $signed({2'b00, dk});
    band_lo  = m_x - $signed({2'b00, dk});
    anom     = (s_x >= band_hi) || (s_x <= band_lo);

    acc_wd.sum = acc_q.sum + {{24{smp_r[23]}}, smp_r};
    acc_wd.sq  = sq_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sq_add[63:0];
    acc_wd.cnt = acc_q.cnt + 24'd1;
    st_wd.mean = fin_res.mean;
    st_wd.dev  = fin_res.dev;

    state_nxt    = state_r;
    acc_vld_nxt  = acc_vld_r;
    st_vld_nxt   = st_vld_r;
    cmd_nxt      = cmd_r;
    kind_nxt     = kind_r;
    smp_nxt      = smp_r;
    status_nxt   = status_r;
    bad_nxt      = bad_r;
    slot_nxt     = slot_r;
    idx_nxt      = idx_r;
    energy_nxt   = energy_r;
    alert_nxt    = alert_r;
    acc_we       = 1'b0;
    st_we        = 1'b0;
    wr_addr      = slot_r;
    fin_start    = 1'b0;
    o_strobe_nxt = 1'b0;
    o_anom_nxt   = 1'b0;
    o_iderr_nxt  = 1'b0;
    o_index_nxt  = '0;
    o_mean_nxt   = '0;
    o_dev_nxt    = '0;
    o_valid_nxt  = 1'b0;
    o_last_nxt   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt    = in_command;
          kind_nxt   = in_reading_kind;
          smp_nxt    = ssos_pkg::sat_sample(in_sample_value);
          status_nxt = in_reading_status;
          bad_nxt    = in_bad;
          slot_nxt   = id_m1[SW-1:0];
          idx_nxt    = '0;
          state_nxt  = (in_command == ssos_pkg::CMD_FIN) ? S_FRD : S_EXEC;
        end
      end
      S_EXEC: begin
        if (temp_ok) begin
          acc_we              = 1'b1;
          acc_vld_nxt[slot_r] = 1'b1;
        end
        if (acc_act && (kind_r == ssos_pkg::KIND_ENERGY)) begin
          if (e_add[48] != e_add[47]) begin
            energy_nxt = e_add[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
          end else begin
            energy_nxt = e_add[47:0];
          end
        end
        if (acc_act && ((status_r == ssos_pkg::STATUS_ALERT) ||
                        (status_r == ssos_pkg::STATUS_CRIT)) && (alert_r != 32'hFFFF_FFFF)) begin
          alert_nxt = alert_r + 32'd1;
        end
        o_strobe_nxt = 1'b1;
        o_last_nxt   = 1'b1;
        o_anom_nxt   = (cmd_r == ssos_pkg::CMD_CHECK) && !bad_r &&
                       (kind_r == ssos_pkg::KIND_TEMP) && anom;
        o_iderr_nxt  = ((cmd_r == ssos_pkg::CMD_ACC) || (cmd_r == ssos_pkg::CMD_CHECK)) && bad_r;
        state_nxt    = S_IDLE;
      end
      S_FRD: begin
        state_nxt = S_FWAIT;
      end
      S_FWAIT: begin
        if (acc_q.cnt != 24'd0) begin
          fin_start = 1'b1;
          state_nxt = S_FRUN;
        end else begin
          o_strobe_nxt = 1'b1;
          o_index_nxt  = 6'(idx_r);
          o_mean_nxt   = st_q.mean;
          o_dev_nxt    = st_q.dev;
          o_last_nxt   = idx_end;
          idx_nxt      = idx_r + SW'(1);
          state_nxt    = idx_end ? S_IDLE : S_FRD;
        end
      end
      S_FRUN: begin
        if (fin_res.done) begin
          st_we              = 1'b1;
          wr_addr            = idx_r;
          st_vld_nxt[idx_r]  = 1'b1;
          o_strobe_nxt       = 1'b1;
          o_index_nxt        = 6'(idx_r);
          o_mean_nxt         = fin_res.mean;
          o_dev_nxt          = fin_res.dev;
          o_valid_nxt        = 1'b1;
          o_last_nxt         = idx_end;
          idx_nxt            = idx_r + SW'(1);
          state_nxt          = idx_end ? S_IDLE : S_FRD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      acc_vld_r  <= '0;
      st_vld_r   <= '0;
      sigma_r    <= ssos_pkg::SIGMA_RESET;
      energy_r   <= '0;
      alert_r    <= '0;
      out_strobe <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      acc_vld_r  <= acc_vld_nxt;
      st_vld_r   <= st_vld_nxt;
      energy_r   <= energy_nxt;
      alert_r    <= alert_nxt;
      out_strobe <= o_strobe_nxt;
      if (cfg_we) begin
        sigma_r <= cfg_wdata;
      end
    end
    cmd_r              <= cmd_nxt;
    kind_r             <= kind_nxt;
    smp_r              <= smp_nxt;
    status_r           <= status_nxt;
    bad_r              <= bad_nxt;
    slot_r             <= slot_nxt;
    idx_r              <= idx_nxt;
    out_anomaly        <= o_anom_nxt;
    out_id_error       <= o_iderr_nxt;
    out_energy_total   <= energy_nxt;
    out_alert_total    <= alert_nxt;
    out_stat_index     <= o_index_nxt;
    out_stat_mean      <= o_mean_nxt;
    out_stat_deviation <= o_dev_nxt;
    out_stat_valid     <= o_valid_nxt;
    out_last           <= o_last_nxt;
  end

endmodule

@@ dv/tb.sv @@
// tb: self-checking bench for sensor_sigma_outlier_stats_unit
// needs ssos_pkg and the unit's rtl; predicts per-sensor stats and outlier flags
module tb;

  typedef struct {
    bit               is_cfg;
    logic [3:0]       cfg_val;
    bit               drain;
    logic [1:0]       cmd;
    logic [7:0]       id;
    logic [2:0]       kind;
    logic signed [23:0] smp;
    logic [1:0]       status;
  } request_t;

  typedef struct {
    logic               anomaly;
    logic               id_error;
    logic signed [47:0] energy;
    logic [31:0]        alerts;
    logic [5:0]         idx;
    logic signed [23:0] mean;
    logic [22:0]        dev;
    logic               valid;
    logic               last;
  } stat_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_command = '0;
  logic [7:0] in_sensor_number = '0;
  logic [2:0] in_reading_kind = '0;
  logic signed [23:0] in_sample_value = '0;
  logic [1:0] in_reading_status = '0;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_wdata = '0;
  logic out_strobe, out_anomaly, out_id_error, out_stat_valid, out_last;
  logic signed [47:0] out_energy_total;
  logic [31:0] out_alert_total;
  logic [5:0] out_stat_index;
  logic signed [23:0] out_stat_mean;
  logic [22:0] out_stat_deviation;

  sensor_sigma_outlier_stats_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_sensor_number(in_sensor_number),
    .in_reading_kind(in_reading_kind), .in_sample_value(in_sample_value),
    .in_reading_status(in_reading_status),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_strobe(out_strobe), .out_anomaly(out_anomaly), .out_id_error(out_id_error),
    .out_energy_total(out_energy_total), .out_alert_total(out_alert_total),
    .out_stat_index(out_stat_index), .out_stat_mean(out_stat_mean),
    .out_stat_deviation(out_stat_deviation), .out_stat_valid(out_stat_valid),
    .out_last(out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow state of the unit
  logic [3:0]         k_sigma = ssos_pkg::SIGMA_RESET;
  longint             sum_m [ssos_pkg::NUM_SENSORS];
  logic [63:0]        sq_m [ssos_pkg::NUM_SENSORS];
  logic [23:0]        cnt_m [ssos_pkg::NUM_SENSORS];
  longint             mean_m [ssos_pkg::NUM_SENSORS];
  longint             dev_m [ssos_pkg::NUM_SENSORS];
  longint             energy_m = 0;
  logic [31:0]        alerts_m = '0;

  request_t     pending_q[$];
  stat_result_t stats_due_q[$];
  bit           failed = 1'b0;

  initial begin
    for (int i = 0; i < ssos_pkg::NUM_SENSORS; i++) begin
      sum_m[i] = 0; sq_m[i] = '0; cnt_m[i] = '0; mean_m[i] = 0; dev_m[i] = 0;
    end
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic stat_result_t totals_only(logic an, logic ide);
    stat_result_t e;
    e.anomaly = an; e.id_error = ide; e.energy = energy_m[47:0]; e.alerts = alerts_m;
    e.idx = '0; e.mean = '0; e.dev = '0; e.valid = 1'b0; e.last = 1'b1;
    return e;
  endfunction

  task automatic predict_stats(request_t r);
    stat_result_t e;
    longint s, m, dk, en;
    logic [63:0] msq, m2, var_v, d, sq;
    int slot;
    bit bad;
    s = r.smp;
    bad = (r.id == 0) || (r.id > ssos_pkg::NUM_SENSORS);
    slot = bad ? 0 : int'(r.id) - 1;
    if (r.cmd == ssos_pkg::CMD_FIN) begin
      for (int i = 0; i < ssos_pkg::NUM_SENSORS; i++) begin
        if (cnt_m[i] != 0) begin
          m = sum_m[i] / longint'(cnt_m[i]);
          msq = sq_m[i] / {40'd0, cnt_m[i]};
          m2 = m * m;
          var_v = (msq > m2) ? msq - m2 : 64'd0;
          d = int_sqrt(var_v);
          if (d > {41'd0, ssos_pkg::DEV_MAX}) d = {41'd0, ssos_pkg::DEV_MAX};
          mean_m[i] = m;
          dev_m[i] = d;
        end
        e = totals_only(1'b0, 1'b0);
        e.idx = 6'(i); e.mean = 24'(mean_m[i]); e.dev = 23'(dev_m[i]);
        e.valid = cnt_m[i] != 0; e.last = (i == ssos_pkg::NUM_SENSORS - 1);
        stats_due_q.push_back(e);
      end
    end else begin
      if (r.cmd == ssos_pkg::CMD_ACC && !bad) begin
        if (r.kind == ssos_pkg::KIND_TEMP && cnt_m[slot] < ssos_pkg::COUNT_MAX) begin
          sq = s * s;
          sum_m[slot] = sum_m[slot] + s;
          sq_m[slot] = (sq > ~sq_m[slot]) ? '1 : sq_m[slot] + sq;
          cnt_m[slot] = cnt_m[slot] + 24'd1;
        end
        if (r.kind == ssos_pkg::KIND_ENERGY) begin
          en = energy_m + s;
          if (en > 64'sh7FFF_FFFF_FFFF) en = 64'sh7FFF_FFFF_FFFF;
          if (en < -64'sh8000_0000_0000) en = -64'sh8000_0000_0000;
          energy_m = en;
        end
        if ((r.status == ssos_pkg::STATUS_ALERT || r.status == ssos_pkg::STATUS_CRIT) &&
            alerts_m != '1)
          alerts_m = alerts_m + 32'd1;
      end
      if (r.cmd == ssos_pkg::CMD_CHECK && !bad && r.kind == ssos_pkg::KIND_TEMP) begin
        dk = dev_m[slot] * longint'(k_sigma);
        e = totals_only((s >= mean_m[slot] + dk) || (s <= mean_m[slot] - dk), 1'b0);
      end else begin
        e = totals_only(1'b0, (r.cmd == ssos_pkg::CMD_ACC || r.cmd == ssos_pkg::CMD_CHECK) &&
                        bad);
      end
      stats_due_q.push_back(e);
    end
  endtask

  // request driver: bursts with random gaps, config only when drained
  int gap_left = 0;
  int burst_left = 4;
  int quiet_cycles = 0;

  always @(posedge clk) begin
    bit go, we_v;
    request_t h;
    go = 1'b0;
    we_v = 1'b0;
    if (rst_n) begin
      if (start && !busy) predict_stats(pending_q.pop_front());
      if (stats_due_q.size() == 0 && !busy && !start) quiet_cycles++;
      else quiet_cycles = 0;
      if (start && busy) begin
        go = 1'b1;
      end else if (pending_q.size() > 0) begin
        h = pending_q[0];
        if (gap_left > 0) begin
          gap_left--;
        end else if (h.is_cfg) begin
          if (quiet_cycles >= 8) begin
            we_v = 1'b1;
            k_sigma = h.cfg_val;
            cfg_wdata <= h.cfg_val;
            void'(pending_q.pop_front());
          end
        end else if (!h.drain || quiet_cycles >= 2) begin
          go = 1'b1;
          in_command <= h.cmd;
          in_sensor_number <= h.id;
          in_reading_kind <= h.kind;
          in_sample_value <= h.smp;
          in_reading_status <= h.status;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
    end
    start <= go;
    cfg_we <= we_v;
  end

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    stat_result_t e;
    if (rst_n && out_strobe) begin
      if (stats_due_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got index %0d", $time,
                 out_stat_index);
        failed = 1'b1;
      end else begin
        e = stats_due_q.pop_front();
        check_field("anomaly", longint'(e.anomaly), longint'(out_anomaly));
        check_field("id_error", longint'(e.id_error), longint'(out_id_error));
        check_field("energy_total", longint'(e.energy), longint'(out_energy_total));
        check_field("alert_total", longint'(e.alerts), longint'(out_alert_total));
        check_field("stat_index", longint'(e.idx), longint'(out_stat_index));
        check_field("stat_mean", longint'(e.mean), longint'(out_stat_mean));
        check_field("stat_deviation", longint'(e.dev), longint'(out_stat_deviation));
        check_field("stat_valid", longint'(e.valid), longint'(out_stat_valid));
        check_field("last", longint'(e.last), longint'(out_last));
      end
    end
  end

  task automatic add_req(logic [1:0] c, logic [7:0] id, logic [2:0] k,
                         logic signed [23:0] v, logic [1:0] st, bit dr = 1'b0);
    request_t r;
    r = '{is_cfg: 1'b0, cfg_val: '0, drain: dr, cmd: c, id: id, kind: k, smp: v,
          status: st};
    pending_q.push_back(r);
  endtask

  task automatic add_cfg(logic [3:0] val);
    request_t r;
    r = '{is_cfg: 1'b1, cfg_val: val, drain: 1'b0, cmd: '0, id: '0, kind: '0,
          smp: '0, status: '0};
    pending_q.push_back(r);
  endtask

  initial begin
    int centre [ssos_pkg::NUM_SENSORS];
    int spread, n, sel;
    logic signed [23:0] v;
    logic [7:0] id;
    for (int i = 0; i < ssos_pkg::NUM_SENSORS; i++)
      centre[i] = int'($urandom_range(0, 20000)) - 10000;

    // directed: never-finalized check, extremes, bad ids, kinds 0 to 5 and 7, all statuses
    add_req(ssos_pkg::CMD_CHECK, 8'd1, ssos_pkg::KIND_TEMP, 24'sd0, ssos_pkg::STATUS_OK);
    add_req(ssos_pkg::CMD_ACC, 8'd1, ssos_pkg::KIND_TEMP, 24'sh7FFFFF, ssos_pkg::STATUS_ALERT);
    add_req(ssos_pkg::CMD_ACC, 8'd1, ssos_pkg::KIND_TEMP, -24'sh800000, ssos_pkg::STATUS_CRIT);
    add_req(ssos_pkg::CMD_ACC, 8'd32, ssos_pkg::KIND_TEMP, 24'sd1234, ssos_pkg::STATUS_UNKNOWN);
    add_req(ssos_pkg::CMD_ACC, 8'd32, ssos_pkg::KIND_TEMP, 24'sd1300, ssos_pkg::STATUS_OK);
    add_req(ssos_pkg::CMD_ACC, 8'd0, ssos_pkg::KIND_TEMP, 24'sd55, ssos_pkg::STATUS_ALERT);
    add_req(ssos_pkg::CMD_ACC, 8'd33, ssos_pkg::KIND_ENERGY, 24'sd55, ssos_pkg::STATUS_ALERT);
    add_req(ssos_pkg::CMD_ACC, 8'd255, ssos_pkg::KIND_TEMP, 24'sd55, ssos_pkg::STATUS_CRIT);
    add_req(ssos_pkg::CMD_ACC, 8'd5, ssos_pkg::KIND_ENERGY, 24'sh7FFFFF, ssos_pkg::STATUS_OK);
    add_req(ssos_pkg::CMD_ACC, 8'd5, ssos_pkg::KIND_ENERGY, -24'sh800000, ssos_pkg::STATUS_OK);
    for (int k = 1; k <= 5; k++)
      add_req(ssos_pkg::CMD_ACC, 8'd6, k[2:0], 24'sd100, k[1:0]);
    add_req(ssos_pkg::CMD_ACC, 8'd6, 3'd7, 24'sd100, ssos_pkg::STATUS_ALERT);
    add_req(ssos_pkg::CMD_SPARE, 8'd6, ssos_pkg::KIND_TEMP, 24'sd100, ssos_pkg::STATUS_ALERT);
    add_req(ssos_pkg::CMD_FIN, 8'd0, ssos_pkg::KIND_TEMP, 24'sd0, ssos_pkg::STATUS_OK);
    add_req(ssos_pkg::CMD_CHECK, 8'd32, ssos_pkg::KIND_TEMP, 24'sd1267, ssos_pkg::STATUS_OK);
    add_req(ssos_pkg::CMD_CHECK, 8'd32, ssos_pkg::KIND_TEMP, 24'sd2000, ssos_pkg::STATUS_OK);
    add_req(ssos_pkg::CMD_CHECK, 8'd1, ssos_pkg::KIND_ENERGY, 24'sd0, ssos_pkg::STATUS_OK);
    add_req(ssos_pkg::CMD_CHECK, 8'd0, ssos_pkg::KIND_TEMP, 24'sd0, ssos_pkg::STATUS_OK);
    add_req(ssos_pkg::CMD_CHECK, 8'd200, ssos_pkg::KIND_TEMP, 24'sd0, ssos_pkg::STATUS_OK);
    add_cfg(4'd0);
    add_req(ssos_pkg::CMD_CHECK, 8'd32, ssos_pkg::KIND_TEMP, 24'sd1267, ssos_pkg::STATUS_OK);
    add_cfg(4'd15);
    add_req(ssos_pkg::CMD_CHECK, 8'd32, ssos_pkg::KIND_TEMP, 24'sd1267, ssos_pkg::STATUS_OK);

    // random: mostly clustered temperature runs, periodic finalize and checks
    for (n = 0; n < 210; n++) begin
      sel = int'($urandom_range(0, 99));
      id = 8'($urandom_range(1, ssos_pkg::NUM_SENSORS));
      spread = ($urandom_range(0, 3) == 0) ? 4000 : 300;
      v = 24'(centre[id - 8'd1] + int'($urandom_range(0, 2 * spread)) - spread);
      if ($urandom_range(0, 11) == 0) v = 24'($urandom);
      if ($urandom_range(0, 15) == 0) id = 8'($urandom_range(0, 255));
      if (n % 45 == 44) begin
        add_cfg(4'($urandom_range(0, 15)));
        add_req(ssos_pkg::CMD_FIN, 8'($urandom), 3'($urandom), 24'($urandom), 2'($urandom));
      end else if (sel < 55) begin
        add_req(ssos_pkg::CMD_ACC, id,
                (sel < 40) ? ssos_pkg::KIND_TEMP : 3'($urandom_range(0, 7)), v,
                2'($urandom), (n == 100));
      end else if (sel < 92) begin
        add_req(ssos_pkg::CMD_CHECK, id,
                (sel < 88) ? ssos_pkg::KIND_TEMP : 3'($urandom_range(0, 7)), v,
                2'($urandom));
      end else begin
        add_req(2'($urandom), 8'($urandom), 3'($urandom), 24'($urandom), 2'($urandom));
      end
    end
    add_req(ssos_pkg::CMD_FIN, 8'd0, ssos_pkg::KIND_TEMP, 24'sd0, ssos_pkg::STATUS_OK);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_q.size() == 0 && !start);
    wait (stats_due_q.size() == 0);
    repeat (300) @(posedge clk);
    if (!failed) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #(12 * 3000000);
    $display("tb NOT OK");
    $finish;
  end

endmodule
